// ===== design/assert_macros.svh =====
// assertion macros used by the port checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define LPSD_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// property checked at every clock edge, reset included
`define LPSD_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/lpsd_pkg.sv =====
// types, constants and helper functions of the led panel scan driver
package lpsd_pkg;

  localparam int SCAN_STEPS    = 4;
  localparam int CHAIN_LENGTH  = 256;
  localparam int ROWS_PER_BAND = 16;
  localparam int PANEL_COLS    = 64;
  localparam int BAND_COUNT    = 3;
  localparam int MAX_BANDS     = 3;

  localparam int STORE_DEPTH = SCAN_STEPS * CHAIN_LENGTH;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  localparam int SCAN_W      = $clog2(SCAN_STEPS);
  localparam int CHAIN_W     = $clog2(CHAIN_LENGTH);
  localparam int BIT_W       = $clog2(2 * CHAIN_LENGTH);
  localparam int TICK_W      = 16;
  localparam int ROW_W       = 6;
  localparam int COL_W       = 6;
  localparam int BAND_W      = 2;

  localparam logic [BIT_W-1:0] LAST_SHIFT_TICK = BIT_W'(2 * CHAIN_LENGTH - 1);

  localparam logic [TICK_W-1:0] BLANK_TICKS_RST  = 16'd10;
  localparam logic [TICK_W-1:0] SETTLE_TICKS_RST = 16'd2;
  localparam logic [TICK_W-1:0] ON_TICKS_RST     = 16'd2500;

  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  typedef enum logic {
    REQ_PIXEL = 1'b0,
    REQ_TICK  = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    REG_BLANK  = 2'd0,
    REG_SETTLE = 2'd1,
    REG_ON     = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    PH_BLANK  = 3'd0,
    PH_ADDR   = 3'd1,
    PH_SHIFT  = 3'd2,
    PH_LATCH  = 3'd3,
    PH_SETTLE = 3'd4,
    PH_ON     = 3'd5
  } phase_e;

  // pin levels after one tick, plus whether the data lines take new bits
  typedef struct packed {
    logic              shift_clock;
    logic              latch_level;
    logic              output_enable;
    logic [SCAN_W-1:0] row_address;
    logic              load_data;
  } pins_t;

  typedef struct packed {
    pins_t               pins;
    logic [STORE_AW-1:0] rd_addr;
  } seq_out_t;

  function automatic logic [BAND_W-1:0] pixel_band(input logic [ROW_W-1:0] row);
    return row[ROW_W-1:4];
  endfunction

  // scan state = row%4, chain bit = (col/8)*32 + ((15-row%16)/4)*8 + col%8
  function automatic logic [STORE_AW-1:0] pixel_addr(input logic [ROW_W-1:0] row,
                                                     input logic [COL_W-1:0] col);
    logic [3:0] r;
    r = row[3:0];
    return {r[1:0], col[5:3], ~r[3:2], col[2:0]};
  endfunction

endpackage

// ===== design/lpsd_band_store.sv =====
// one-bit-wide band store with one write port and a registered read port
module lpsd_band_store import lpsd_pkg::*; #(
  parameter int Depth = STORE_DEPTH
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic                     wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic                     rdata_o
);

  logic mem_q [Depth];
  logic rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/lpsd_scan_seq.sv =====
// refresh sequencer: phase, scan state, bit and tick counters, control pins
module lpsd_scan_seq import lpsd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [TICK_W-1:0] blank_ticks_i,
  input  logic [TICK_W-1:0] settle_ticks_i,
  input  logic [TICK_W-1:0] on_ticks_i,
  output seq_out_t          seq_o
);

  phase_e              phase_q, phase_d;
  logic [SCAN_W-1:0]   scan_q, scan_d;
  logic [BIT_W-1:0]    bit_q, bit_d;
  logic [TICK_W-1:0]   tick_q, tick_d;
  logic                clk_q, clk_d;
  logic                lat_q, lat_d;
  logic                oe_q, oe_d;
  logic [SCAN_W-1:0]   addr_q, addr_d;
  logic                load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_BLANK;
      scan_q  <= '0;
      bit_q   <= '0;
      tick_q  <= '0;
      clk_q   <= 1'b0;
      lat_q   <= 1'b1;
      oe_q    <= 1'b0;
      addr_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      scan_q  <= scan_d;
      bit_q   <= bit_d;
      tick_q  <= tick_d;
      clk_q   <= clk_d;
      lat_q   <= lat_d;
      oe_q    <= oe_d;
      addr_q  <= addr_d;
    end
  end

  always_comb begin
    phase_d = phase_q;
    scan_d  = scan_q;
    bit_d   = bit_q;
    tick_d  = tick_q;
    clk_d   = clk_q;
    lat_d   = lat_q;
    oe_d    = oe_q;
    addr_d  = addr_q;
    load    = 1'b0;

    // phases whose count has run out fall through within the same tick
    if (phase_d == PH_SETTLE && tick_d >= settle_ticks_i) begin
      tick_d  = '0;
      phase_d = PH_ON;
    end
    if (phase_d == PH_ON && tick_d >= on_ticks_i) begin
      tick_d  = '0;
      scan_d  = scan_d + SCAN_W'(1);
      phase_d = PH_BLANK;
    end
    if (!(phase_d inside {PH_ADDR, PH_SHIFT, PH_LATCH, PH_SETTLE, PH_ON})) begin
      phase_d = PH_BLANK;
      oe_d    = 1'b0;
      if (tick_d >= blank_ticks_i) begin
        tick_d  = '0;
        phase_d = PH_ADDR;
      end
    end

    case (phase_d)
      PH_ADDR: begin
        addr_d  = scan_d;
        oe_d    = 1'b0;
        phase_d = PH_SHIFT;
        bit_d   = '0;
      end
      PH_SHIFT: begin
        if (!bit_q[0]) begin
          load  = 1'b1;
          clk_d = 1'b0;
        end else begin
          clk_d = 1'b1;
        end
        if (bit_q == LAST_SHIFT_TICK) begin
          phase_d = PH_LATCH;
          bit_d   = '0;
        end else begin
          bit_d = bit_q + BIT_W'(1);
        end
      end
      PH_LATCH: begin
        if (bit_q == '0) begin
          lat_d = 1'b0;
          clk_d = 1'b0;
          bit_d = BIT_W'(1);
        end else begin
          lat_d   = 1'b1;
          bit_d   = '0;
          tick_d  = '0;
          phase_d = PH_SETTLE;
        end
      end
      PH_SETTLE: begin
        tick_d = tick_d + TICK_W'(1);
      end
      PH_ON: begin
        oe_d   = 1'b1;
        tick_d = tick_d + TICK_W'(1);
      end
      default: begin
        tick_d = tick_d + TICK_W'(1);
      end
    endcase
  end

  assign seq_o.pins.shift_clock   = clk_d;
  assign seq_o.pins.latch_level   = lat_d;
  assign seq_o.pins.output_enable = oe_d;
  assign seq_o.pins.row_address   = addr_d;
  assign seq_o.pins.load_data     = load;
  assign seq_o.rd_addr            = {scan_q, bit_q[BIT_W-1:1]};

endmodule

// ===== design/led_panel_scan_driver_top.sv =====
// top level of the quarter scan led panel driver
//
//   channel | direction | handshake                    | payload
//   --------+-----------+------------------------------+-------------------------------------
//   in      | sink      | in_valid_i / in_stall_o      | req_type, pixel_row, pixel_col, pixel_on
//   out     | source    | out_valid_o / out_stall_i    | shift_clock .. data_z (pin levels)
//   cfg     | apb slave | psel penable pwrite pready   | blank, settle, on tick counts
//
// one item is taken every cycle while in_stall_o is low; a tick result passes the read stage
// (band store read) and then the result register before it reaches the outputs
// after reset the band stores are cleared one address per cycle, all 1024 addresses, with in_stall_o
// held high; configuration writes are taken throughout
// a stalled result holds in the output register while the pipe behind it keeps filling
module led_panel_scan_driver_top import lpsd_pkg::*; #(
  parameter int BandCount = BAND_COUNT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // request channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              req_type_i,
  input  logic [ROW_W-1:0]  pixel_row_i,
  input  logic [COL_W-1:0]  pixel_col_i,
  input  logic              pixel_on_i,
  // pin level channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              shift_clock_o,
  output logic              latch_level_o,
  output logic              output_enable_o,
  output logic [SCAN_W-1:0] row_address_o,
  output logic              data_x_o,
  output logic              data_y_o,
  output logic              data_z_o,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  // configuration registers
  logic [TICK_W-1:0] blank_ticks_q, settle_ticks_q, on_ticks_q;
  reg_idx_e          cfg_idx;
  logic              cfg_wr;

  // band store clearing pass
  logic                clr_busy_q;
  logic [STORE_AW-1:0] clr_addr_q;

  // input register
  logic             s1_valid_q;
  req_e             s1_req_q;
  logic [ROW_W-1:0] s1_row_q;
  logic [COL_W-1:0] s1_col_q;
  logic             s1_on_q;

  // read stage
  logic  s2_valid_q;
  pins_t s2_pins_q;

  // result register and live data line levels
  logic                 out_valid_q;
  pins_t                out_pins_q;
  logic [MAX_BANDS-1:0] data_q, data_d;

  logic                 out_ready, s2_ready, s1_go, tick_step, pix_step, accept;
  logic                 s2_move;
  seq_out_t             seq;
  logic [BAND_W-1:0]    pix_band;
  logic [STORE_AW-1:0]  pix_addr;
  logic [MAX_BANDS-1:0] rd_bits;

  // ---------------------------------------------------------------------------
  // configuration port: registers at byte addresses 0, 4 and 8
  // ---------------------------------------------------------------------------
  assign cfg_idx = reg_idx_e'(paddr[APB_AW-1:2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blank_ticks_q  <= BLANK_TICKS_RST;
      settle_ticks_q <= SETTLE_TICKS_RST;
      on_ticks_q     <= ON_TICKS_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_BLANK:  blank_ticks_q  <= pwdata[TICK_W-1:0];
        REG_SETTLE: settle_ticks_q <= pwdata[TICK_W-1:0];
        REG_ON:     on_ticks_q     <= pwdata[TICK_W-1:0];
        default: ;  // unmapped address, write dropped
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_BLANK:  prdata = APB_DW'(blank_ticks_q);
      REG_SETTLE: prdata = APB_DW'(settle_ticks_q);
      REG_ON:     prdata = APB_DW'(on_ticks_q);
      default:    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // flow control: each stage moves when the one after it has room
  // ---------------------------------------------------------------------------
  assign out_ready = !out_valid_q || !out_stall_i;
  assign s2_ready  = !s2_valid_q || out_ready;
  assign s2_move   = s2_valid_q && out_ready;
  // a pixel write finishes in the input register and never waits on the result side
  assign s1_go     = s1_valid_q && ((s1_req_q == REQ_PIXEL) || s2_ready);
  assign tick_step = s1_go && (s1_req_q == REQ_TICK);
  assign pix_step  = s1_go && (s1_req_q == REQ_PIXEL);
  assign in_stall_o = clr_busy_q || (s1_valid_q && !s1_go);
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + STORE_AW'(1);
      if (clr_addr_q == STORE_AW'(STORE_DEPTH - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_go) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_req_q <= req_e'(req_type_i);
      s1_row_q <= pixel_row_i;
      s1_col_q <= pixel_col_i;
      s1_on_q  <= pixel_on_i;
    end
  end

  // ---------------------------------------------------------------------------
  // refresh sequencer, stepped once per tick leaving the input register
  // ---------------------------------------------------------------------------
  lpsd_scan_seq u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (tick_step),
    .blank_ticks_i  (blank_ticks_q),
    .settle_ticks_i (settle_ticks_q),
    .on_ticks_i     (on_ticks_q),
    .seq_o          (seq)
  );

  // ---------------------------------------------------------------------------
  // band stores: pixel writes, clearing pass and the shift read
  // ---------------------------------------------------------------------------
  assign pix_band = pixel_band(s1_row_q);
  assign pix_addr = pixel_addr(s1_row_q, s1_col_q);

  for (genvar b = 0; b < MAX_BANDS; b++) begin : g_band
    if (b < BandCount) begin : g_store
      logic                we;
      logic [STORE_AW-1:0] waddr;
      logic                wdata;

      assign we    = clr_busy_q || (pix_step && (pix_band == BAND_W'(b)));
      assign waddr = clr_busy_q ? clr_addr_q : pix_addr;
      assign wdata = !clr_busy_q && s1_on_q;

      lpsd_band_store #(
        .Depth (STORE_DEPTH)
      ) u_store (
        .clk_i   (clk_i),
        .we_i    (we),
        .waddr_i (waddr),
        .wdata_i (wdata),
        .re_i    (tick_step),
        .raddr_i (seq.rd_addr),
        .rdata_o (rd_bits[b])
      );
      // active low data: a lit pixel drives the line low
      assign data_d[b] = (s2_pins_q.load_data) ? !rd_bits[b] : data_q[b];
    end else begin : g_absent
      // band not fitted: its data line rests high
      assign rd_bits[b] = 1'b0;
      assign data_d[b]  = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // read stage and result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (tick_step) begin
      s2_valid_q <= 1'b1;
    end else if (s2_move) begin
      s2_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_step) begin
      s2_pins_q <= seq.pins;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      data_q      <= '1;
    end else begin
      if (s2_move) begin
        out_valid_q <= 1'b1;
        data_q      <= data_d;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_move) begin
      out_pins_q <= s2_pins_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign shift_clock_o   = out_pins_q.shift_clock;
  assign latch_level_o   = out_pins_q.latch_level;
  assign output_enable_o = out_pins_q.output_enable;
  assign row_address_o   = out_pins_q.row_address;
  assign data_x_o        = data_q[0];
  assign data_y_o        = data_q[1];
  assign data_z_o        = data_q[2];

endmodule

// ===== design/lpsd_port_checker.sv =====
// port level checks of the led panel scan driver, bound to the top level
`include "assert_macros.svh"

module lpsd_port_checker import lpsd_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic              shift_clock_o,
  input logic              latch_level_o,
  input logic              output_enable_o,
  input logic [SCAN_W-1:0] row_address_o,
  input logic              data_x_o,
  input logic              data_y_o,
  input logic              data_z_o
);

  logic              stalled;
  logic              latch_low;
  logic [SCAN_W+5:0] pins;

  assign stalled   = out_valid_o && out_stall_i;
  assign latch_low = out_valid_o && !latch_level_o;
  assign pins      = {shift_clock_o, latch_level_o, output_enable_o, row_address_o,
                      data_x_o, data_y_o, data_z_o};

  // no result shows while reset is applied
  `LPSD_ASSERT_ALWAYS(a_idle_in_reset, clk_i, !rst_ni |-> !out_valid_o, "result in reset")

  // a stalled result keeps its pin levels
  `LPSD_ASSERT(a_stall_holds, clk_i, rst_ni, stalled |=> out_valid_o && $stable(pins), "pins moved")

  // rows are never lit while the latch is low
  `LPSD_ASSERT(a_dark_on_latch, clk_i, rst_ni, latch_low |-> !output_enable_o, "lit on latch")

  // the shift clock is low while the latch pulse is low
  `LPSD_ASSERT(a_clk_on_latch, clk_i, rst_ni, latch_low |-> !shift_clock_o, "clock high on latch")

endmodule

bind led_panel_scan_driver_top lpsd_port_checker u_lpsd_port_checker (.*);

// ===== bench/tb_top.sv =====
// self-checking bench for the led panel scan driver: pixel writes and refresh ticks
`timescale 1ns / 100ps
module tb_top import lpsd_pkg::*; ();

  // the config port decodes one address past the last register, writes there must be ignored
  localparam logic [APB_AW-1:0] UNUSED_REG_ADDR = APB_AW'(12);
  localparam int GAP_MAX = 10;
  // a pixel write gives no transfer out, so let it drain from the input register into the band store
  localparam int QUIET_CYCLES = 6;
  localparam int DRAIN_CYCLES = 8;

  typedef enum int {
    IDLE_NONE,
    IDLE_FULL,
    IDLE_SOME
  } idle_mode_e;

  // pin levels as the panel sees them after one refresh tick
  typedef struct packed {
    logic              shift_clock;
    logic              latch_level;
    logic              output_enable;
    logic [SCAN_W-1:0] row_address;
    logic              data_x;
    logic              data_y;
    logic              data_z;
  } pin_levels_t;

  function automatic logic [APB_AW-1:0] reg_addr(input reg_idx_e idx);
    return APB_AW'({idx, 2'b00});
  endfunction

  function automatic int draw_gap(input idle_mode_e mode);
    case (mode)
      IDLE_FULL: return int'($urandom_range(0, GAP_MAX));
      IDLE_SOME: return ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, GAP_MAX)) : 0;
      default:   return 0;
    endcase
  endfunction

  // tracks the band stores and the scan sequence, and queues the pin levels each tick gives
  class pin_tracker;
    bit                lit [BAND_COUNT][SCAN_STEPS*CHAIN_LENGTH];
    phase_e            phase;
    logic [SCAN_W-1:0] scan;
    int unsigned       shift_pos;
    int unsigned       count;
    pin_levels_t       pins;
    logic [TICK_W-1:0] blank_len;
    logic [TICK_W-1:0] settle_len;
    logic [TICK_W-1:0] on_len;
    pin_levels_t       pending_pins[$];
    int unsigned       errors;

    function new();
      foreach (lit[b, a]) lit[b][a] = 1'b0;
      phase       = PH_BLANK;
      scan        = '0;
      shift_pos   = 0;
      count       = 0;
      pins        = '0;
      pins.latch_level = 1'b1;
      pins.data_x = 1'b1;
      pins.data_y = 1'b1;
      pins.data_z = 1'b1;
      blank_len   = 16'd10;
      settle_len  = 16'd2;
      on_len      = 16'd2500;
      errors      = 0;
    endfunction

    function void note(input string msg);
      errors++;
      $display("%0t: %s", $time, msg);
    endfunction

    function void set_reg(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
      if (addr == reg_addr(REG_BLANK)) blank_len = data[TICK_W-1:0];
      else if (addr == reg_addr(REG_SETTLE)) settle_len = data[TICK_W-1:0];
      else if (addr == reg_addr(REG_ON)) on_len = data[TICK_W-1:0];
    endfunction

    function void write_pixel(input int unsigned row, input int unsigned col, input bit lit_on);
      int unsigned band;
      int unsigned r;
      int unsigned pos;
      band = row / ROWS_PER_BAND;
      if (band >= BAND_COUNT) return;
      r   = row % ROWS_PER_BAND;
      pos = (col / 8) * 32 + ((15 - r) / 4) * 8 + col % 8;
      lit[band][(r % SCAN_STEPS) * CHAIN_LENGTH + pos] = lit_on;
    endfunction

    // data lines are active low, a band that is not fitted keeps its line high
    function logic line_level(input int band, input int unsigned a);
      return (band < BAND_COUNT) ? ~lit[band][a] : 1'b1;
    endfunction

    function void load_data(input int unsigned bit_no);
      int unsigned a;
      a = scan * CHAIN_LENGTH + bit_no;
      pins.data_x = line_level(0, a);
      pins.data_y = line_level(1, a);
      pins.data_z = line_level(2, a);
    endfunction

    // one refresh tick; phases with a zero count fall through within the same tick
    function void step_refresh();
      bit done;
      done = 1'b0;
      while (!done) begin
        case (phase)
          PH_ADDR: begin
            pins.row_address   = scan;
            pins.output_enable = 1'b0;
            phase              = PH_SHIFT;
            shift_pos          = 0;
            done               = 1'b1;
          end
          PH_SHIFT: begin
            if (shift_pos % 2 == 0) begin
              load_data(shift_pos / 2);
              pins.shift_clock = 1'b0;
            end else begin
              pins.shift_clock = 1'b1;
            end
            shift_pos++;
            if (shift_pos >= 2 * CHAIN_LENGTH) begin
              phase     = PH_LATCH;
              shift_pos = 0;
            end
            done = 1'b1;
          end
          PH_LATCH: begin
            if (shift_pos == 0) begin
              pins.latch_level = 1'b0;
              pins.shift_clock = 1'b0;
              shift_pos        = 1;
            end else begin
              pins.latch_level = 1'b1;
              shift_pos        = 0;
              count            = 0;
              phase            = PH_SETTLE;
            end
            done = 1'b1;
          end
          PH_SETTLE: begin
            if (count < settle_len) begin
              count++;
              done = 1'b1;
            end else begin
              count = 0;
              phase = PH_ON;
            end
          end
          PH_ON: begin
            if (count < on_len) begin
              pins.output_enable = 1'b1;
              count++;
              done = 1'b1;
            end else begin
              count = 0;
              scan  = SCAN_W'((scan + 1) % SCAN_STEPS);
              phase = PH_BLANK;
            end
          end
          default: begin
            phase              = PH_BLANK;
            pins.output_enable = 1'b0;
            if (count < blank_len) begin
              count++;
              done = 1'b1;
            end else begin
              count = 0;
              phase = PH_ADDR;
            end
          end
        endcase
      end
    endfunction

    function void take_request(input req_e kind, input logic [ROW_W-1:0] row,
                               input logic [COL_W-1:0] col, input logic lit_on);
      if (kind == REQ_PIXEL) begin
        write_pixel(row, col, lit_on);
      end else begin
        step_refresh();
        pending_pins.push_back(pins);
      end
    endfunction

    function void compare(input string name, input logic [SCAN_W-1:0] want,
                          input logic [SCAN_W-1:0] got);
      if (got !== want) note($sformatf("%s expected %0d got %0d", name, want, got));
    endfunction

    function void check_pins(input pin_levels_t got);
      pin_levels_t want;
      if (pending_pins.size() == 0) begin
        note($sformatf("pin levels %b arrived with nothing expected", got));
        return;
      end
      want = pending_pins.pop_front();
      compare("shift_clock", want.shift_clock, got.shift_clock);
      compare("latch_level", want.latch_level, got.latch_level);
      compare("output_enable", want.output_enable, got.output_enable);
      compare("row_address", want.row_address, got.row_address);
      compare("data_x", want.data_x, got.data_x);
      compare("data_y", want.data_y, got.data_y);
      compare("data_z", want.data_z, got.data_z);
    endfunction
  endclass

  // every input starts at a known level; reset is pulled low at time zero so it takes effect
  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b1;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic              req_type_i = 1'b0;
  logic [ROW_W-1:0]  pixel_row_i = '0;
  logic [COL_W-1:0]  pixel_col_i = '0;
  logic              pixel_on_i = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic              shift_clock_o;
  logic              latch_level_o;
  logic              output_enable_o;
  logic [SCAN_W-1:0] row_address_o;
  logic              data_x_o;
  logic              data_y_o;
  logic              data_z_o;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  // how each side idles in the current stretch of the run
  idle_mode_e in_idle = IDLE_NONE;
  idle_mode_e out_idle = IDLE_NONE;

  pin_tracker panel = new();

  led_panel_scan_driver_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .req_type_i      (req_type_i),
    .pixel_row_i     (pixel_row_i),
    .pixel_col_i     (pixel_col_i),
    .pixel_on_i      (pixel_on_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .shift_clock_o   (shift_clock_o),
    .latch_level_o   (latch_level_o),
    .output_enable_o (output_enable_o),
    .row_address_o   (row_address_o),
    .data_x_o        (data_x_o),
    .data_y_o        (data_y_o),
    .data_z_o        (data_z_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // one request transfer; valid only drops when a gap is drawn, so back-to-back items keep it high
  task automatic send_req(input req_e kind, input logic [ROW_W-1:0] row,
                          input logic [COL_W-1:0] col, input logic lit_on);
    int gap;
    gap = draw_gap(in_idle);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    req_type_i  <= kind;
    pixel_row_i <= row;
    pixel_col_i <= col;
    pixel_on_i  <= lit_on;
    do @(posedge clk_i); while (in_stall_o);
    panel.take_request(kind, row, col, lit_on);
  endtask

  // mostly rows in range, with some in the unfitted rows 48..63 that must be ignored
  task automatic send_random(input int tick_pct);
    req_e             kind;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             lit_on;
    kind   = ($urandom_range(1, 100) <= tick_pct) ? REQ_TICK : REQ_PIXEL;
    row    = ($urandom_range(0, 9) == 0) ? ROW_W'($urandom_range(48, 63))
                                         : ROW_W'($urandom_range(0, 47));
    col    = COL_W'($urandom());
    lit_on = 1'($urandom());
    send_req(kind, row, col, lit_on);
  endtask

  // apb write: setup cycle, access cycle, then psel is driven low again
  task automatic cfg_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    panel.set_reg(addr, data);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic cfg_read_check(input logic [APB_AW-1:0] addr, input logic [TICK_W-1:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== APB_DW'(want))
      panel.note($sformatf("register at %0h expected %0h got %0h", addr, want, prdata));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_regs();
    cfg_read_check(reg_addr(REG_BLANK), panel.blank_len);
    cfg_read_check(reg_addr(REG_SETTLE), panel.settle_len);
    cfg_read_check(reg_addr(REG_ON), panel.on_len);
  endtask

  // upper data bits are random, only the low 16 reach a register
  task automatic apply_config(input logic [TICK_W-1:0] blank_len, settle_len, on_len);
    cfg_write(reg_addr(REG_BLANK), APB_DW'({TICK_W'($urandom()), blank_len}));
    cfg_write(reg_addr(REG_SETTLE), APB_DW'({TICK_W'($urandom()), settle_len}));
    cfg_write(reg_addr(REG_ON), APB_DW'({TICK_W'($urandom()), on_len}));
    check_regs();
  endtask

  // config only changes once every tick result is out and trailing pixel writes have drained;
  // valid drops first so the last request is not taken again
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (panel.pending_pins.size() != 0) @(posedge clk_i);
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [TICK_W-1:0] blank_len, settle_len, on_len,
                           input int n_items, input int tick_pct,
                           input idle_mode_e in_mode, input idle_mode_e out_mode);
    wait_idle();
    apply_config(blank_len, settle_len, on_len);
    in_idle  = in_mode;
    out_idle = out_mode;
    repeat (n_items) send_random(tick_pct);
  endtask

  // result side: check each transfer, then maybe hold stall for a drawn number of cycles
  initial begin : pin_sink
    int          hold;
    pin_levels_t got;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        got = {shift_clock_o, latch_level_o, output_enable_o, row_address_o,
               data_x_o, data_y_o, data_z_o};
        panel.check_pins(got);
        hold = draw_gap(out_idle);
        if (hold > 0) begin
          out_stall_i <= 1'b1;
          repeat (hold) @(posedge clk_i);
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  initial begin : stimulus
    rst_ni <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // registers must read their reset values, even while the stores are being cleared
    check_regs();

    // directed: corner pixels of every band, a clear, unfitted rows, then ticks at reset timing
    in_idle  = IDLE_NONE;
    out_idle = IDLE_SOME;
    send_req(REQ_PIXEL, 6'd0, 6'd0, 1'b1);
    send_req(REQ_PIXEL, 6'd47, 6'd63, 1'b1);
    send_req(REQ_PIXEL, 6'd15, 6'd0, 1'b1);
    send_req(REQ_PIXEL, 6'd16, 6'd63, 1'b1);
    send_req(REQ_PIXEL, 6'd31, 6'd7, 1'b1);
    send_req(REQ_PIXEL, 6'd32, 6'd56, 1'b1);
    send_req(REQ_PIXEL, 6'd15, 6'd0, 1'b0);
    send_req(REQ_PIXEL, 6'd48, 6'd5, 1'b1);
    send_req(REQ_PIXEL, 6'd63, 6'd63, 1'b1);
    send_req(REQ_PIXEL, 6'd42, 6'd21, 1'b0);
    repeat (14) send_req(REQ_TICK, ROW_W'($urandom()), COL_W'($urandom()), 1'($urandom()));

    // all counts zero: any count phase falls through within one tick
    run_phase(16'd0, 16'd0, 16'd0, 120, 90, IDLE_NONE, IDLE_NONE);
    run_phase(16'd3, 16'd1, 16'd4, 80, 85, IDLE_FULL, IDLE_FULL);
    // longest counts
    run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 60, 90, IDLE_SOME, IDLE_SOME);

    // a write past the last register must not disturb any of them
    wait_idle();
    cfg_write(UNUSED_REG_ADDR, APB_DW'($urandom()));
    check_regs();

    // short counts after the longest ones
    run_phase(16'd2, 16'd0, 16'd1, 40, 85, IDLE_SOME, IDLE_FULL);
    run_phase(TICK_W'($urandom_range(0, 40)), TICK_W'($urandom_range(0, 40)),
              TICK_W'($urandom_range(0, 40)), 40, 85, IDLE_FULL, IDLE_SOME);
    run_phase(16'd10, 16'd2, 16'd2500, 40, 70, IDLE_NONE, IDLE_FULL);
    in_valid_i <= 1'b0;

    while (panel.pending_pins.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (panel.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // the worst case run, including the store clearing pass after reset, ends well before this watchdog fires
  initial begin : watchdog
    #5000000;
    $display("status: fail");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/lpsd_pkg.sv
design/lpsd_band_store.sv
design/lpsd_scan_seq.sv
design/led_panel_scan_driver_top.sv
design/lpsd_port_checker.sv
bench/tb_top.sv
